@@ design/gsa_pkg.sv @@
// Shared types, codes and sizes for the grouped sales aggregate filter unit.
// Used by every module of the block but gsa_ram; depends on nothing.
`timescale 1ns / 1ps

package gsa_pkg;

	// table geometry
	localparam int PART_KEY_BITS = 16;
	localparam int KEY_COUNT     = 1 << PART_KEY_BITS;
	localparam int BRAND_DIGITS  = 5;
	localparam int BRAND_BITS    = 5;
	localparam int POS_BITS      = BRAND_BITS + PART_KEY_BITS;
	localparam int CURSOR_BITS   = POS_BITS + 1;

	// field and total widths
	localparam int QTY_IN_BITS   = 16;
	localparam int PRICE_BITS    = 24;
	localparam int REV_IN_BITS   = QTY_IN_BITS + PRICE_BITS;
	localparam int QTY_BITS      = 32;
	localparam int REV_BITS      = 64;
	localparam int TOTAL_BITS    = 48;
	localparam int COUNT_BITS    = 17;
	localparam int THR_BITS      = 4;
	localparam int PROD_BITS     = QTY_BITS + COUNT_BITS;
	localparam int LHS_BITS      = PROD_BITS + 4;
	localparam int RHS_BITS      = TOTAL_BITS + THR_BITS;

	localparam logic [THR_BITS-1:0] THR_RESET = 4'd3;

	// request function codes
	localparam logic [1:0] FUNC_LOAD   = 2'd0;
	localparam logic [1:0] FUNC_ORDER  = 2'd1;
	localparam logic [1:0] FUNC_FINISH = 2'd2;
	localparam logic [1:0] FUNC_REPORT = 2'd3;

	typedef struct packed {
		logic [1:0]             func;
		logic [15:0]            part_key;
		logic [2:0]             brand_major;
		logic [2:0]             brand_minor;
		logic [QTY_IN_BITS-1:0] quantity;
		logic [PRICE_BITS-1:0]  unit_price;
	} req_t;

	typedef struct packed {
		logic [15:0]           result_part_key;
		logic [4:0]            brand_index;
		logic [QTY_BITS-1:0]   part_quantity;
		logic [REV_BITS-1:0]   part_revenue;
		logic [TOTAL_BITS-1:0] grand_quantity;
		logic [COUNT_BITS-1:0] counted_parts;
		logic                  report_done;
	} rsp_t;

	// classified command passed from front to back
	typedef struct packed {
		logic [1:0]               func;
		logic [PART_KEY_BITS-1:0] key;
		logic [BRAND_BITS-1:0]    brand;
		logic [QTY_IN_BITS-1:0]   qty;
		logic [REV_IN_BITS-1:0]   rev;
	} cmd_t;

	// command queue status
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

@@ design/grouped_sales_aggregate_filter_unit.sv @@
// Top level of the grouped sales aggregate filter unit.
// Depends on gsa_pkg, gsa_front, gsa_queue and gsa_back.
`timescale 1ns / 1ps

// Usage:
//  Requests enter on req_valid/req_stall/req_data, one per accepted edge.
//  Results leave on rsp_valid/rsp_stall/rsp_data from an output register.
//  The threshold in tenths is written through cfg_wr_en/cfg_wr_data; the user
//  must write it only while idle, which the block itself does not enforce.
//  After reset a clearing pass sweeps all 65536 keys of the part flag tables,
//  one key a cycle, with req_stall high. A request passes an input register
//  and a two-entry queue before the back end executes it. An order reads,
//  then writes the part entry; a finish yields its result through the output
//  register. A report walks all 65536 part entries through a three-stage
//  compare pipeline, then reads the chosen part. Invalid loads and orders for
//  unloaded parts leave no trace. While rsp_stall holds a result, loads and
//  orders keep executing and the queue keeps filling; a finish waits until the
//  register frees, and a report scans but holds its result until then.

module grouped_sales_aggregate_filter_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  gsa_pkg::req_t                req_data,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output gsa_pkg::rsp_t                rsp_data,
	input  logic                         cfg_wr_en,
	input  logic [gsa_pkg::THR_BITS-1:0] cfg_wr_data
);

	logic               push;
	logic               pop;
	logic               clearing;
	gsa_pkg::cmd_t      push_cmd;
	gsa_pkg::cmd_t      head;
	gsa_pkg::q_status_t q_status;

	gsa_front u_front (
		.clk(clk), .arst_n(arst_n), .hold(clearing),
		.req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
		.q_status(q_status), .push(push), .push_cmd(push_cmd)
	);

	gsa_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_cmd(push_cmd),
		.pop(pop), .head(head), .status(q_status)
	);

	gsa_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.head(head), .q_status(q_status), .pop(pop), .clearing(clearing),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
	);

endmodule

@@ design/gsa_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

module gsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ design/gsa_front.sv @@
// Front end: takes requests, checks load digits, forms brand index and revenue.
// Depends on gsa_pkg; feeds gsa_queue.
`timescale 1ns / 1ps

module gsa_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  hold,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  gsa_pkg::req_t         req_data,
	input  gsa_pkg::q_status_t    q_status,
	output logic                  push,
	output gsa_pkg::cmd_t         push_cmd
);

	logic          valid_s1;
	gsa_pkg::req_t data_s1;
	logic          digits_ok;
	logic          useful;
	logic          retire;
	logic [5:0]    brand_wide;

	// a load with a digit out of range is dropped here
	assign digits_ok = (data_s1.brand_major != 3'd0)
		&& (data_s1.brand_major <= 3'(gsa_pkg::BRAND_DIGITS))
		&& (data_s1.brand_minor != 3'd0)
		&& (data_s1.brand_minor <= 3'(gsa_pkg::BRAND_DIGITS));
	assign useful = (data_s1.func != gsa_pkg::FUNC_LOAD) || digits_ok;

	assign retire    = valid_s1 && (!useful || !q_status.full);
	assign push      = valid_s1 && useful && !q_status.full;
	assign req_stall = hold || (valid_s1 && !retire);

	// brand index and line revenue
	assign brand_wide = ({3'b0, data_s1.brand_major} - 6'd1) * 6'(gsa_pkg::BRAND_DIGITS)
		+ ({3'b0, data_s1.brand_minor} - 6'd1);

	always_comb begin
		push_cmd.func  = data_s1.func;
		push_cmd.key   = data_s1.part_key[gsa_pkg::PART_KEY_BITS-1:0];
		push_cmd.brand = brand_wide[gsa_pkg::BRAND_BITS-1:0];
		push_cmd.qty   = data_s1.quantity;
		push_cmd.rev   = gsa_pkg::REV_IN_BITS'(data_s1.quantity)
			* gsa_pkg::REV_IN_BITS'(data_s1.unit_price);
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			valid_s1 <= 1'b1;
		end else if (retire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			data_s1 <= req_data;
		end
	end

endmodule

@@ design/gsa_queue.sv @@
// Two-entry command queue between front and back ends.
// Depends on gsa_pkg for the command and status types.
`timescale 1ns / 1ps

module gsa_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  gsa_pkg::cmd_t      push_cmd,
	input  logic               pop,
	output gsa_pkg::cmd_t      head,
	output gsa_pkg::q_status_t status
);

	gsa_pkg::cmd_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign head         = entry_q[rd_ptr_q];
	assign status.full  = (count_q == 2'd2);
	assign status.empty = (count_q == 2'd0);

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

@@ design/gsa_back.sv @@
// Back end: part tables, totals, report scan and the result register.
// Depends on gsa_pkg and gsa_ram; takes commands from gsa_queue.
`timescale 1ns / 1ps

module gsa_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [gsa_pkg::THR_BITS-1:0]  cfg_wr_data,
	input  gsa_pkg::cmd_t                 head,
	input  gsa_pkg::q_status_t            q_status,
	output logic                          pop,
	output logic                          clearing,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output gsa_pkg::rsp_t                 rsp_data
);

	localparam logic [3:0] ST_CLEAR  = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_ORD    = 4'd2;
	localparam logic [3:0] ST_SCAN   = 4'd3;
	localparam logic [3:0] ST_DRAIN  = 4'd4;
	localparam logic [3:0] ST_FETCH  = 4'd5;
	localparam logic [3:0] ST_RESULT = 4'd6;

	localparam int KB = gsa_pkg::PART_KEY_BITS;

	logic [3:0]                       st_q;
	gsa_pkg::cmd_t                    cmd_q;
	logic [KB-1:0]                    clr_q;
	logic [gsa_pkg::THR_BITS-1:0]     thr_q;
	logic [gsa_pkg::TOTAL_BITS-1:0]   total_q;
	logic [gsa_pkg::COUNT_BITS-1:0]   parts_q;
	logic [gsa_pkg::CURSOR_BITS-1:0]  cursor_q;
	logic [gsa_pkg::RHS_BITS-1:0]     rhs_q;
	logic [KB-1:0]                    scan_k_q;
	logic [gsa_pkg::POS_BITS-1:0]     best_q;
	logic                             best_v_q;
	logic                             next_v_q;
	logic                             rsp_valid_q;
	gsa_pkg::rsp_t                    rsp_q;

	// scan pipeline
	logic                             v_s1, v_s2, v_s3;
	logic [KB-1:0]                    key_s1;
	logic [gsa_pkg::PROD_BITS-1:0]    prod_s2;
	logic [gsa_pkg::POS_BITS-1:0]     pos_s2, pos_s3;
	logic                             cnt_s2, cnt_s3;
	logic [gsa_pkg::LHS_BITS-1:0]     lhs_s3;
	logic                             cand;

	// memory ports
	logic [KB-1:0]                    rd_addr, wr_addr;
	logic                             we_brand, we_loaded, we_counted, we_order;
	logic                             flag_wdata;
	logic                             loaded_rd, counted_rd;
	logic [gsa_pkg::BRAND_BITS-1:0]   brand_rd;
	logic [gsa_pkg::QTY_BITS-1:0]     qty_rd, qty_new;
	logic [gsa_pkg::REV_BITS-1:0]     rev_rd, rev_new;
	logic [gsa_pkg::QTY_BITS:0]       qty_sum;
	logic [gsa_pkg::REV_BITS:0]       rev_sum;
	logic [gsa_pkg::TOTAL_BITS:0]     total_sum;
	logic                             out_free;
	logic                             take;
	logic                             rsp_load;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign clearing  = (st_q == ST_CLEAR);
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// take a command; finish needs the result register free
	assign take = (st_q == ST_IDLE) && !q_status.empty
		&& ((head.func != gsa_pkg::FUNC_FINISH) || out_free);
	assign pop = take;

	// result register loads on a finish or a found report part
	assign rsp_load = (take && head.func == gsa_pkg::FUNC_FINISH)
		|| (st_q == ST_RESULT && out_free);

	// memory address and write control
	always_comb begin
		rd_addr    = cmd_q.key;
		wr_addr    = cmd_q.key;
		we_brand   = 1'b0;
		we_loaded  = 1'b0;
		we_counted = 1'b0;
		we_order   = 1'b0;
		flag_wdata = 1'b1;
		unique case (st_q)
			ST_CLEAR: begin
				wr_addr    = clr_q;
				we_loaded  = 1'b1;
				we_counted = 1'b1;
				flag_wdata = 1'b0;
			end
			ST_IDLE: begin
				rd_addr = head.key;
				wr_addr = head.key;
				if (take && head.func == gsa_pkg::FUNC_LOAD) begin
					we_brand  = 1'b1;
					we_loaded = 1'b1;
				end
			end
			ST_ORD: begin
				we_counted = loaded_rd;
				we_order   = loaded_rd;
			end
			ST_SCAN: begin
				rd_addr = scan_k_q;
			end
			ST_FETCH, ST_RESULT: begin
				rd_addr = best_q[KB-1:0];
			end
			default: begin
			end
		endcase
	end

	// saturating updates of one part's totals
	assign qty_sum = {1'b0, qty_rd} + (gsa_pkg::QTY_BITS+1)'(cmd_q.qty);
	assign rev_sum = {1'b0, rev_rd} + (gsa_pkg::REV_BITS+1)'(cmd_q.rev);
	always_comb begin
		if (!counted_rd) begin
			qty_new = gsa_pkg::QTY_BITS'(cmd_q.qty);
			rev_new = gsa_pkg::REV_BITS'(cmd_q.rev);
		end else begin
			qty_new = qty_sum[gsa_pkg::QTY_BITS] ? '1 : qty_sum[gsa_pkg::QTY_BITS-1:0];
			rev_new = rev_sum[gsa_pkg::REV_BITS] ? '1 : rev_sum[gsa_pkg::REV_BITS-1:0];
		end
	end
	assign total_sum = {1'b0, total_q} + (gsa_pkg::TOTAL_BITS+1)'(cmd_q.qty);

	// part tables
	gsa_ram #(.WIDTH(gsa_pkg::BRAND_BITS), .DEPTH(gsa_pkg::KEY_COUNT)) u_brand (
		.clk(clk), .wr_en(we_brand), .wr_addr(wr_addr), .wr_data(head.brand),
		.rd_addr(rd_addr), .rd_data(brand_rd)
	);
	gsa_ram #(.WIDTH(1), .DEPTH(gsa_pkg::KEY_COUNT)) u_loaded (
		.clk(clk), .wr_en(we_loaded), .wr_addr(wr_addr), .wr_data(flag_wdata),
		.rd_addr(rd_addr), .rd_data(loaded_rd)
	);
	gsa_ram #(.WIDTH(1), .DEPTH(gsa_pkg::KEY_COUNT)) u_counted (
		.clk(clk), .wr_en(we_counted), .wr_addr(wr_addr), .wr_data(flag_wdata),
		.rd_addr(rd_addr), .rd_data(counted_rd)
	);
	gsa_ram #(.WIDTH(gsa_pkg::QTY_BITS), .DEPTH(gsa_pkg::KEY_COUNT)) u_qty (
		.clk(clk), .wr_en(we_order), .wr_addr(wr_addr), .wr_data(qty_new),
		.rd_addr(rd_addr), .rd_data(qty_rd)
	);
	gsa_ram #(.WIDTH(gsa_pkg::REV_BITS), .DEPTH(gsa_pkg::KEY_COUNT)) u_rev (
		.clk(clk), .wr_en(we_order), .wr_addr(wr_addr), .wr_data(rev_new),
		.rd_addr(rd_addr), .rd_data(rev_rd)
	);

	// scan candidate: counted, below threshold, at or after the cursor
	assign cand = v_s3 && cnt_s3 && (lhs_s3 < gsa_pkg::LHS_BITS'(rhs_q))
		&& ({1'b0, pos_s3} >= cursor_q);

	// scan pipeline stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= (st_q == ST_SCAN);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		key_s1  <= scan_k_q;
		prod_s2 <= gsa_pkg::PROD_BITS'(qty_rd) * gsa_pkg::PROD_BITS'(parts_q);
		pos_s2  <= {brand_rd, key_s1};
		cnt_s2  <= counted_rd;
		lhs_s3  <= (gsa_pkg::LHS_BITS'(prod_s2) << 3) + (gsa_pkg::LHS_BITS'(prod_s2) << 1);
		pos_s3  <= pos_s2;
		cnt_s3  <= cnt_s2;
	end

	always_ff @(posedge clk) begin
		if (take && head.func == gsa_pkg::FUNC_REPORT) begin
			rhs_q <= gsa_pkg::RHS_BITS'(total_q) * gsa_pkg::RHS_BITS'(thr_q);
		end
		if (take) begin
			cmd_q <= head;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLEAR;
			clr_q       <= '0;
			thr_q       <= gsa_pkg::THR_RESET;
			total_q     <= '0;
			parts_q     <= '0;
			cursor_q    <= '0;
			scan_k_q    <= '0;
			best_q      <= '0;
			best_v_q    <= 1'b0;
			next_v_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (cfg_wr_en) begin
				thr_q <= cfg_wr_data;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (cand) begin
				if (!best_v_q || pos_s3 < best_q) begin
					best_q <= pos_s3;
				end
				best_v_q <= 1'b1;
				next_v_q <= next_v_q || best_v_q;
			end
			unique case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (take) begin
						unique case (head.func)
							gsa_pkg::FUNC_ORDER: begin
								st_q <= ST_ORD;
							end
							gsa_pkg::FUNC_FINISH: begin
								rsp_q.result_part_key <= '0;
								rsp_q.brand_index     <= '0;
								rsp_q.part_quantity   <= '0;
								rsp_q.part_revenue    <= '0;
								rsp_q.grand_quantity  <= total_q;
								rsp_q.counted_parts   <= parts_q;
								rsp_q.report_done     <= 1'b0;
								cursor_q              <= '0;
							end
							gsa_pkg::FUNC_REPORT: begin
								scan_k_q <= '0;
								best_v_q <= 1'b0;
								next_v_q <= 1'b0;
								st_q     <= ST_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_ORD: begin
					if (loaded_rd) begin
						total_q <= total_sum[gsa_pkg::TOTAL_BITS]
							? '1 : total_sum[gsa_pkg::TOTAL_BITS-1:0];
						if (!counted_rd && parts_q != '1) begin
							parts_q <= parts_q + 1'b1;
						end
					end
					st_q <= ST_IDLE;
				end
				ST_SCAN: begin
					scan_k_q <= scan_k_q + 1'b1;
					if (scan_k_q == '1) begin
						st_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2 && !v_s3) begin
						st_q <= best_v_q ? ST_FETCH : ST_IDLE;
					end
				end
				ST_FETCH: begin
					st_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (out_free) begin
						rsp_q.result_part_key       <= 16'(best_q[KB-1:0]);
						rsp_q.brand_index           <= brand_rd;
						rsp_q.part_quantity         <= qty_rd;
						rsp_q.part_revenue          <= rev_rd;
						rsp_q.grand_quantity        <= total_q;
						rsp_q.counted_parts         <= parts_q;
						rsp_q.report_done           <= !next_v_q;
						cursor_q <= gsa_pkg::CURSOR_BITS'(best_q) + 1'b1;
						st_q     <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// checks
	a_clear_no_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CLEAR) |-> !rsp_valid_q)
		else $error("result raised during clearing pass");
	a_ord_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_ORD) |=> (st_q == ST_IDLE))
		else $error("order update did not return to idle");
	a_scan_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (st_q == ST_SCAN || st_q == ST_DRAIN))
		else $error("scan pipeline active outside scan");
	a_next_needs_best: assert property (@(posedge clk) disable iff (!arst_n)
		next_v_q |-> best_v_q)
		else $error("second candidate without first");

endmodule
